// File: sv/next_fit_id_allocator_unit_defines.svh
// Assertion macros shared by the allocator checker.
`ifndef NEXT_FIT_ID_ALLOCATOR_UNIT_DEFINES_SVH
`define NEXT_FIT_ID_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define NFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define NFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: sv/nfa_pkg.sv
// Shared types, codes and helpers of the next-fit id allocator.
package nfa_pkg;

  localparam int MAX_ID    = 127;
  localparam int ID_W      = 7;
  localparam int NUM_SLOTS = 1 << ID_W;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int EM_W      = 3;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
  localparam logic [OP_W-1:0] OP_DETACH  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [EM_W-1:0] EM_GRANT   = 3'd0;
  localparam logic [EM_W-1:0] EM_FULL    = 3'd1;
  localparam logic [EM_W-1:0] EM_RANGE   = 3'd2;
  localparam logic [EM_W-1:0] EM_RELEASE = 3'd3;
  localparam logic [EM_W-1:0] EM_LOOKUP  = 3'd4;
  localparam logic [EM_W-1:0] EM_DETACH  = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] parent_id;
  } nfa_req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] granted_id;
    logic            entry_present;
    logic [ID_W-1:0] entry_parent;
    logic            table_full;
  } nfa_rsp_t;

  typedef struct packed {
    logic            load;
    logic            advance;
    logic            sweep;
    logic            emit;
    logic [EM_W-1:0] kind;
  } nfa_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;
    logic            slot_free;
    logic            scan_last;
    logic            sweep_last;
  } nfa_stat_t;

  function automatic logic [ID_W-1:0] next_slot(input logic [ID_W-1:0] s);
    if (s >= ID_W'(MAX_ID)) begin
      next_slot = ID_W'(1);
    end else begin
      next_slot = s + ID_W'(1);
    end
  endfunction

  function automatic logic id_valid(input logic [ID_W-1:0] v);
    id_valid = (v != '0) && (v <= ID_W'(MAX_ID));
  endfunction

endpackage

// File: sv/nfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/nfa_ctrl.sv
// Controller state machine sequencing allocate, release, lookup and detach.
module nfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  nfa_pkg::nfa_stat_t stat,
  output nfa_pkg::nfa_cmd_t  cmd,
  output logic              busy
);

  import nfa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_DETACH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((stat.op != OP_ALLOC) && !stat.id_ok) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_RANGE;
          state_next = S_IDLE;
        end else begin
          case (stat.op)
            OP_ALLOC:   state_next = S_SCAN;
            OP_RELEASE: begin
              cmd.emit   = 1'b1;
              cmd.kind   = EM_RELEASE;
              state_next = S_IDLE;
            end
            OP_LOOKUP:  state_next = S_LOOKUP;
            OP_DETACH:  state_next = S_DETACH;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_GRANT;
          state_next = S_IDLE;
        end else if (stat.scan_last) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_LOOKUP: begin
        cmd.emit   = 1'b1;
        cmd.kind   = EM_LOOKUP;
        state_next = S_IDLE;
      end
      S_DETACH: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EM_DETACH;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: sv/nfa_dp.sv
// Datapath: used bits, parent RAM, scan pointer, flags and result register.
module nfa_dp (
  input  logic               clk,
  input  logic               rst,
  input  nfa_pkg::nfa_req_t  req,
  input  nfa_pkg::nfa_cmd_t  cmd,
  output nfa_pkg::nfa_stat_t stat,
  output logic               done,
  output nfa_pkg::nfa_rsp_t  rsp
);

  import nfa_pkg::*;

  nfa_req_t              req_q;
  logic [NUM_SLOTS-1:0]  used;
  logic [ID_W-1:0]       ptr;
  logic [ID_W-1:0]       ptr_d;
  logic [ID_W-1:0]       cnt;
  logic [ID_W-1:0]       last_granted;
  logic                  full;
  logic                  full_next;
  nfa_rsp_t              rsp_next;

  logic                  ram_we;
  logic [ID_W-1:0]       ram_waddr;
  logic [ID_W-1:0]       ram_wdata;
  logic [ID_W-1:0]       ram_rdata;
  logic                  sweep_hit;
  logic                  do_grant;
  logic                  do_release;

  nfa_ram #(
    .WIDTH(ID_W),
    .DEPTH(NUM_SLOTS)
  ) u_parent_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  assign sweep_hit  = cmd.sweep && used[ptr_d] && (ram_rdata == req_q.id);
  assign do_grant   = cmd.emit && (cmd.kind == EM_GRANT);
  assign do_release = cmd.emit && (cmd.kind == EM_RELEASE) && used[ptr];

  assign ram_we    = do_grant || sweep_hit;
  assign ram_waddr = do_grant ? ptr : ptr_d;
  assign ram_wdata = do_grant ? req_q.parent_id : '0;

  assign stat.op         = req_q.operation;
  assign stat.id_ok      = id_valid(req_q.id);
  assign stat.slot_free  = !used[ptr];
  assign stat.scan_last  = (cnt == ID_W'(MAX_ID - 1));
  assign stat.sweep_last = (ptr_d == ID_W'(MAX_ID));

  always_comb begin
    full_next = full;
    if (cmd.emit && (cmd.kind == EM_FULL)) begin
      full_next = 1'b1;
    end else if (do_release) begin
      full_next = 1'b0;
    end
  end

  always_comb begin
    rsp_next            = '0;
    rsp_next.status     = ST_OK;
    rsp_next.table_full = full_next;
    unique case (cmd.kind)
      EM_GRANT:   rsp_next.granted_id = ptr;
      EM_FULL:    rsp_next.status = ST_MISS;
      EM_RANGE:   rsp_next.status = ST_RANGE;
      EM_RELEASE: rsp_next.status = used[ptr] ? ST_OK : ST_MISS;
      EM_LOOKUP: begin
        rsp_next.status        = used[ptr] ? ST_OK : ST_MISS;
        rsp_next.entry_present = used[ptr];
        rsp_next.entry_parent  = used[ptr] ? ram_rdata : '0;
      end
      EM_DETACH:  rsp_next.status = ST_OK;
      default:    rsp_next.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      last_granted <= '0;
      full         <= 1'b0;
      done         <= 1'b0;
      ptr          <= '0;
    end else begin
      done <= cmd.emit;
      full <= full_next;
      if (cmd.load) begin
        if (req.operation == OP_ALLOC) begin
          ptr <= next_slot(last_granted);
        end else if (req.operation == OP_DETACH) begin
          ptr <= ID_W'(1);
        end else begin
          ptr <= req.id;
        end
      end else if (cmd.advance) begin
        ptr <= next_slot(ptr);
      end
      if (do_grant) begin
        used[ptr]    <= 1'b1;
        last_granted <= ptr;
      end
      if (do_release) begin
        used[ptr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_d <= ptr;
    if (cmd.load) begin
      req_q <= req;
      cnt   <= '0;
    end else if (cmd.advance) begin
      cnt <= cnt + ID_W'(1);
    end
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: sv/next_fit_id_allocator_unit.sv
// Top level of the next-fit id allocator: controller plus datapath.
//
// Usage: drive req with start high; the beat is taken on an edge where start
// is high and busy is low. Exactly one result beat follows on rsp, marked by
// done for one cycle; the receiver cannot stall it and must take it then.
// Busy is low again in the cycle done is shown, so a new beat may start there.
// Controller sequence from accept to done:
//   release, or a non-allocate request with its id out of range: decode only
//   lookup: decode, then lookup (one registered read of the parent RAM)
//   allocate: decode, then k free-slot scan steps (1..MAX_ID), one used
//     bit tested per cycle starting after the last granted id
//   detach: decode, then a sweep of ids 1 to MAX_ID, one parent RAM entry
//     swept per cycle after a registered read lead
// Reset (rst, synchronous) frees every slot, zeroes the last granted id and
// the full flag, and leaves the block idle; the parent RAM needs no clearing
// since a parent is read only for a slot marked used.
module next_fit_id_allocator_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  nfa_pkg::nfa_req_t req,
  output logic              done,
  output nfa_pkg::nfa_rsp_t rsp
);

  import nfa_pkg::*;

  nfa_cmd_t  cmd;
  nfa_stat_t stat;

  nfa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  nfa_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .done(done),
    .rsp (rsp)
  );

endmodule

// File: sv/nfa_checker.sv
// Port-level checker for the next-fit id allocator, bound to the top level.
`include "next_fit_id_allocator_unit_defines.svh"

module nfa_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input nfa_pkg::nfa_rsp_t rsp
);

  import nfa_pkg::*;

  `NFA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `NFA_ASSERT_IMP(a_done_idle, done, !busy)
  `NFA_ASSERT_IMP(a_status_code, done,
                  (rsp.status == ST_OK) || (rsp.status == ST_MISS) || (rsp.status == ST_RANGE))
  `NFA_ASSERT_IMP(a_grant_ok, done && (rsp.granted_id != '0), rsp.status == ST_OK)
  `NFA_ASSERT_IMP(a_range_clean, done && (rsp.status == ST_RANGE),
                  (rsp.granted_id == '0) && !rsp.entry_present)

endmodule

bind next_fit_id_allocator_unit nfa_checker u_nfa_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);
